>>> hdl/c8_pkg.sv
`timescale 1ns / 1ps

package c8_pkg;

    // machine sizes
    localparam int ADDR_W     = 12;
    localparam int MEM_DEPTH  = 4096;
    localparam int ROWS       = 32;
    localparam int ROW_W      = 64;
    localparam int NUM_REGS   = 16;
    localparam int STACK_D    = 16;
    localparam int FONT_BYTES = 80;

    localparam logic [11:0] FONT_BASE   = 12'h050;
    localparam logic [11:0] START_RESET = 12'h200;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;

    // instruction codes
    localparam logic [15:0] INST_CLS = 16'h00E0;
    localparam logic [15:0] INST_RET = 16'h00EE;
    localparam logic [7:0]  NN_SKP   = 8'h9E;
    localparam logic [7:0]  NN_SKNP  = 8'hA1;
    localparam logic [7:0]  NN_GETDT = 8'h07;
    localparam logic [7:0]  NN_WAITK = 8'h0A;
    localparam logic [7:0]  NN_SETDT = 8'h15;
    localparam logic [7:0]  NN_SETST = 8'h18;
    localparam logic [7:0]  NN_ADDI  = 8'h1E;
    localparam logic [7:0]  NN_FONT  = 8'h29;
    localparam logic [7:0]  NN_BCD   = 8'h33;
    localparam logic [7:0]  NN_STORE = 8'h55;
    localparam logic [7:0]  NN_LOAD  = 8'h65;

    // hexadecimal font glyphs
    localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [2:0] {
        EV_EXEC = 3'd0,
        EV_TICK = 3'd1,
        EV_KEY  = 3'd2,
        EV_LOAD = 3'd3,
        EV_ROW  = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
        ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL, ALU_EQ
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        logic [7:0] a;
        logic [7:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] y;
        logic       flag;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_FLAG, S_CLS,
        S_RET, S_D1, S_D2, S_BCD, S_ST1, S_ST2, S_LD1, S_LD2, S_RESP
    } t_state;

endpackage

>>> hdl/chip8_interpreter_core.sv
`timescale 1ns / 1ps
// chip8 interpreter core
// input word: opcode plus event fields, taken when start is high and busy is low.
// events: execute one instruction, timer tick, key change, memory byte load,
// display row read. every event gives exactly one result word, shown for one
// cycle with o_strobe high; the receiver cannot stall it.
// tick, key, load, row read and unused opcodes go straight to the result; execute
// runs the fetch of both opcode bytes, the Vx and Vy reads and execute, plus a stack
// read for RET or a VF write for the flag-setting 8XY ops; CLS, sprite draw, FX55/FX65
// and FX33 loop over rows, registers or digits.
// one event at a time; the loops run through a single byte ALU and
// memories with one write and one registered read port, one step per cycle.
// start_address is written through i_cfg_we / i_cfg_data and loads the PC.
// after reset a clearing pass over every memory address loads the font, blanks memory,
// display, registers and stack; busy stays high until it ends.

module chip8_interpreter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    input  logic [2:0]  i_opcode,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_data,
    input  logic [3:0]  i_key_number,
    input  logic        i_key_pressed,
    input  logic [4:0]  i_row_select,
    output logic        o_strobe,
    output logic [11:0] o_program_counter,
    output logic [11:0] o_index_value,
    output logic        o_display_changed,
    output logic        o_waiting_key,
    output logic        o_tone_on,
    output logic        o_beep_pulse,
    output logic [63:0] o_row_pixels
);

    import c8_pkg::*;

    t_state r_state, n_state;
    logic [11:0] r_clr, n_clr;
    logic [11:0] r_start, n_start;
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_i, n_i;
    logic [3:0]  r_sp, n_sp;
    logic [7:0]  r_dt, n_dt;
    logic [7:0]  r_st, n_st;
    logic [15:0] r_keys, n_keys;
    logic        r_wait, n_wait;
    logic [3:0]  r_wtgt, n_wtgt;
    logic [15:0] r_lfsr, n_lfsr;
    logic        r_strobe, n_strobe;

    logic [15:0] r_inst, n_inst;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic        r_flag, n_flag;
    logic        r_drew, n_drew;
    logic        r_beep, n_beep;
    logic        r_isrow, n_isrow;
    logic [7:0]  r_bv, n_bv;
    logic [3:0]  r_dig, n_dig;

    logic [11:0] r_o_pc, r_o_i;
    logic        r_o_drew, r_o_wait, r_o_tone, r_o_beep;
    logic [63:0] r_o_row;

    // memory ports
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        fb_we;
    logic [4:0]  fb_waddr, fb_raddr;
    logic [63:0] fb_wdata, fb_rdata;
    logic        v_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, v_rdata;
    logic        stk_we;
    logic [3:0]  stk_waddr, stk_raddr;
    logic [11:0] stk_wdata, stk_rdata;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // decode helpers
    logic [3:0]   ix, iy, in_n;
    logic [7:0]   nn;
    logic [11:0]  nnn, pc2, pc4, i_off, font_off;
    logic [4:0]   draw_row;
    logic [63:0]  sprite_line, draw_mask;
    logic [127:0] rot;
    logic         lfsr_bit;
    logic [15:0]  lfsr_next;
    logic         key_hit;

    assign ix       = r_inst[11:8];
    assign iy       = r_inst[7:4];
    assign in_n     = r_inst[3:0];
    assign nn       = r_inst[7:0];
    assign nnn      = r_inst[11:0];
    assign pc2      = r_pc + 12'd2;
    assign pc4      = r_pc + 12'd4;
    assign i_off    = r_i + {7'd0, r_cnt};
    assign font_off = r_clr - FONT_BASE;
    assign draw_row = r_vy[4:0] + {1'b0, r_cnt[3:0]};
    assign sprite_line = {mem_rdata, 56'd0};
    assign rot       = {sprite_line, sprite_line} >> r_vx[5:0];
    assign draw_mask = rot[63:0];
    assign lfsr_bit  = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
    assign lfsr_next = {lfsr_bit, r_lfsr[15:1]};
    assign key_hit   = r_keys[r_vx[3:0]];

    c8_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    c8_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_main_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    c8_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_frame (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    c8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_vregs (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    c8_ram #(.WIDTH(12), .DEPTH(STACK_D)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_start  <= START_RESET;
            r_pc     <= START_RESET;
            r_i      <= '0;
            r_sp     <= '0;
            r_dt     <= '0;
            r_st     <= '0;
            r_keys   <= '0;
            r_wait   <= 1'b0;
            r_wtgt   <= '0;
            r_lfsr   <= LFSR_SEED;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_start  <= n_start;
            r_pc     <= n_pc;
            r_i      <= n_i;
            r_sp     <= n_sp;
            r_dt     <= n_dt;
            r_st     <= n_st;
            r_keys   <= n_keys;
            r_wait   <= n_wait;
            r_wtgt   <= n_wtgt;
            r_lfsr   <= n_lfsr;
            r_strobe <= n_strobe;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_inst  <= n_inst;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_cnt   <= n_cnt;
        r_hit   <= n_hit;
        r_flag  <= n_flag;
        r_drew  <= n_drew;
        r_beep  <= n_beep;
        r_isrow <= n_isrow;
        r_bv    <= n_bv;
        r_dig   <= n_dig;
        if (r_state == S_RESP) begin
            r_o_pc   <= r_pc;
            r_o_i    <= r_i;
            r_o_drew <= r_drew;
            r_o_wait <= r_wait;
            r_o_tone <= (r_st != 8'd0);
            r_o_beep <= r_beep;
            r_o_row  <= r_isrow ? fb_rdata : 64'd0;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_start  = r_start;
        n_pc     = r_pc;
        n_i      = r_i;
        n_sp     = r_sp;
        n_dt     = r_dt;
        n_st     = r_st;
        n_keys   = r_keys;
        n_wait   = r_wait;
        n_wtgt   = r_wtgt;
        n_lfsr   = r_lfsr;
        n_strobe = 1'b0;
        n_inst   = r_inst;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_flag   = r_flag;
        n_drew   = r_drew;
        n_beep   = r_beep;
        n_isrow  = r_isrow;
        n_bv     = r_bv;
        n_dig    = r_dig;

        mem_we    = 1'b0;
        mem_waddr = i_off;
        mem_wdata = r_vx;
        mem_raddr = r_pc;
        fb_we     = 1'b0;
        fb_waddr  = draw_row;
        fb_wdata  = fb_rdata ^ draw_mask;
        fb_raddr  = draw_row;
        v_we      = 1'b0;
        v_waddr   = ix;
        v_wdata   = alu_rsp.y;
        v_raddr   = ix;
        stk_we    = 1'b0;
        stk_waddr = r_sp;
        stk_wdata = pc2;
        stk_raddr = r_sp - 4'd1;

        alu_req.op = ALU_EQ;
        alu_req.a  = r_vx;
        alu_req.b  = r_vy;

        case (r_state)
            // power-up sweep over every store
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr >= FONT_BASE && font_off < 12'(FONT_BYTES))
                            ? FONT[font_off[6:0]] : 8'd0;
                fb_we     = 1'b1;
                fb_waddr  = r_clr[4:0];
                fb_wdata  = 64'd0;
                v_we      = 1'b1;
                v_waddr   = r_clr[3:0];
                v_wdata   = 8'd0;
                stk_we    = 1'b1;
                stk_waddr = r_clr[3:0];
                stk_wdata = 12'd0;
                n_clr     = r_clr + 12'd1;
                if (r_clr == 12'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // accept an event word
            S_IDLE: begin
                fb_raddr = i_row_select;
                mem_raddr = r_pc;
                if (start) begin
                    n_drew  = 1'b0;
                    n_beep  = 1'b0;
                    n_isrow = 1'b0;
                    n_state = S_RESP;
                    case (i_opcode)
                        EV_EXEC: begin
                            if (!r_wait) begin
                                n_state = S_F1;
                            end
                        end
                        EV_TICK: begin
                            if (r_dt != 8'd0) begin
                                n_dt = r_dt - 8'd1;
                            end
                            if (r_st != 8'd0) begin
                                n_st   = r_st - 8'd1;
                                n_beep = (r_st == 8'd2);
                            end
                        end
                        EV_KEY: begin
                            if (i_key_pressed) begin
                                n_keys = r_keys | (16'd1 << i_key_number);
                                if (r_wait) begin
                                    v_we    = 1'b1;
                                    v_waddr = r_wtgt;
                                    v_wdata = {4'd0, i_key_number};
                                    n_pc    = pc2;
                                    n_wait  = 1'b0;
                                end
                            end else begin
                                n_keys = r_keys & ~(16'd1 << i_key_number);
                            end
                        end
                        EV_LOAD: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_load_address;
                            mem_wdata = i_load_data;
                        end
                        EV_ROW: begin
                            n_isrow = 1'b1;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // instruction fetch and operand reads
            S_F1: begin
                n_inst[15:8] = mem_rdata;
                mem_raddr    = r_pc + 12'd1;
                n_state      = S_F2;
            end
            S_F2: begin
                n_inst[7:0] = mem_rdata;
                v_raddr     = ix;
                n_state     = S_RX;
            end
            S_RX: begin
                n_vx    = v_rdata;
                v_raddr = iy;
                n_state = S_RY;
            end
            S_RY: begin
                n_vy    = v_rdata;
                v_raddr = 4'd0;
                n_state = S_EXEC;
            end

            // execute, v_rdata holds V0 here
            S_EXEC: begin
                n_pc    = pc2;
                n_state = S_RESP;
                case (r_inst[15:12])
                    4'h0: begin
                        if (r_inst == INST_CLS) begin
                            n_drew  = 1'b1;
                            n_cnt   = 5'd0;
                            n_state = S_CLS;
                        end else if (r_inst == INST_RET && r_sp != 4'd0) begin
                            n_sp    = r_sp - 4'd1;
                            n_state = S_RET;
                        end
                    end
                    4'h1: n_pc = nnn;
                    4'h2: begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + 4'd1;
                        n_pc   = nnn;
                    end
                    4'h3: begin
                        alu_req.b = nn;
                        if (alu_rsp.flag) n_pc = pc4;
                    end
                    4'h4: begin
                        alu_req.b = nn;
                        if (!alu_rsp.flag) n_pc = pc4;
                    end
                    4'h5: begin
                        if (in_n == 4'd0 && alu_rsp.flag) n_pc = pc4;
                    end
                    4'h9: begin
                        if (in_n == 4'd0 && !alu_rsp.flag) n_pc = pc4;
                    end
                    4'h6: begin
                        v_we    = 1'b1;
                        v_wdata = nn;
                    end
                    4'h7: begin
                        alu_req.op = ALU_ADD;
                        alu_req.b  = nn;
                        v_we       = 1'b1;
                    end
                    4'h8: begin
                        v_we = 1'b1;
                        case (in_n)
                            4'h0: alu_req.op = ALU_MOV;
                            4'h1: alu_req.op = ALU_OR;
                            4'h2: alu_req.op = ALU_AND;
                            4'h3: alu_req.op = ALU_XOR;
                            4'h4: alu_req.op = ALU_ADD;
                            4'h5: alu_req.op = ALU_SUB;
                            4'h6: alu_req.op = ALU_SHR;
                            4'h7: alu_req.op = ALU_SUBN;
                            4'hE: alu_req.op = ALU_SHL;
                            default: v_we = 1'b0;
                        endcase
                        n_flag = alu_rsp.flag;
                        if (in_n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
                            n_state = S_FLAG;
                        end
                    end
                    4'hA: n_i = nnn;
                    4'hB: n_pc = nnn + {4'd0, v_rdata};
                    4'hC: begin
                        n_lfsr     = lfsr_next;
                        alu_req.op = ALU_AND;
                        alu_req.a  = lfsr_next[7:0];
                        alu_req.b  = nn;
                        v_we       = 1'b1;
                    end
                    4'hD: begin
                        n_drew = 1'b1;
                        n_hit  = 1'b0;
                        n_cnt  = 5'd0;
                        if (in_n == 4'd0) begin
                            v_we    = 1'b1;
                            v_waddr = 4'hF;
                            v_wdata = 8'd0;
                        end else begin
                            n_state = S_D1;
                        end
                    end
                    4'hE: begin
                        if (nn == NN_SKP && key_hit) n_pc = pc4;
                        if (nn == NN_SKNP && !key_hit) n_pc = pc4;
                    end
                    default: begin
                        case (nn)
                            NN_GETDT: begin
                                v_we    = 1'b1;
                                v_wdata = r_dt;
                            end
                            NN_WAITK: begin
                                n_wait = 1'b1;
                                n_wtgt = ix;
                                n_pc   = r_pc;
                            end
                            NN_SETDT: n_dt = r_vx;
                            NN_SETST: n_st = r_vx;
                            NN_ADDI:  n_i = r_i + {4'd0, r_vx};
                            NN_FONT:  n_i = FONT_BASE + ({4'd0, r_vx} << 2)
                                          + {4'd0, r_vx};
                            NN_BCD: begin
                                n_bv    = r_vx;
                                n_dig   = 4'd0;
                                n_cnt   = 5'd0;
                                n_state = S_BCD;
                            end
                            NN_STORE: begin
                                n_cnt   = 5'd0;
                                n_state = S_ST1;
                            end
                            NN_LOAD: begin
                                n_cnt   = 5'd0;
                                n_state = S_LD1;
                            end
                            default: n_state = S_RESP;
                        endcase
                    end
                endcase
            end

            // flag written after Vx
            S_FLAG: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'd0, r_flag};
                n_state = S_RESP;
            end

            // blank the display one row a cycle
            S_CLS: begin
                fb_we    = 1'b1;
                fb_waddr = r_cnt;
                fb_wdata = 64'd0;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(ROWS - 1)) begin
                    n_state = S_RESP;
                end
            end

            S_RET: begin
                n_pc    = stk_rdata;
                n_state = S_RESP;
            end

            // sprite row fetch
            S_D1: begin
                mem_raddr = i_off;
                fb_raddr  = draw_row;
                n_state   = S_D2;
            end
            // sprite row xor and collision
            S_D2: begin
                fb_we = 1'b1;
                n_hit = r_hit | (|(fb_rdata & draw_mask));
                n_cnt = r_cnt + 5'd1;
                if (r_cnt[3:0] + 4'd1 == in_n) begin
                    v_we    = 1'b1;
                    v_waddr = 4'hF;
                    v_wdata = {7'd0, n_hit};
                    n_state = S_RESP;
                end else begin
                    n_state = S_D1;
                end
            end

            // decimal digits by repeated subtraction
            S_BCD: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_bv;
                alu_req.b  = (r_cnt == 5'd0) ? 8'd100 : 8'd10;
                if (r_cnt == 5'd2) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_bv;
                    n_state   = S_RESP;
                end else if (alu_rsp.flag) begin
                    n_bv  = alu_rsp.y;
                    n_dig = r_dig + 4'd1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = {4'd0, r_dig};
                    n_dig     = 4'd0;
                    n_cnt     = r_cnt + 5'd1;
                end
            end

            // register block store
            S_ST1: begin
                v_raddr = r_cnt[3:0];
                n_state = S_ST2;
            end
            S_ST2: begin
                mem_we    = 1'b1;
                mem_wdata = v_rdata;
                n_cnt     = r_cnt + 5'd1;
                n_state   = (r_cnt[3:0] == ix) ? S_RESP : S_ST1;
            end

            // register block load
            S_LD1: begin
                mem_raddr = i_off;
                n_state   = S_LD2;
            end
            S_LD2: begin
                v_we    = 1'b1;
                v_waddr = r_cnt[3:0];
                v_wdata = mem_rdata;
                n_cnt   = r_cnt + 5'd1;
                n_state = (r_cnt[3:0] == ix) ? S_RESP : S_LD1;
            end

            // present the result word
            S_RESP: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        // start address write also loads the pc
        if (i_cfg_we) begin
            n_start = i_cfg_data;
            n_pc    = i_cfg_data;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_program_counter = r_o_pc;
    assign o_index_value     = r_o_i;
    assign o_display_changed = r_o_drew;
    assign o_waiting_key     = r_o_wait;
    assign o_tone_on         = r_o_tone;
    assign o_beep_pulse      = r_o_beep;
    assign o_row_pixels      = r_o_row;

endmodule

>>> hdl/c8_ram.sv
`timescale 1ns / 1ps

module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/c8_alu.sv
`timescale 1ns / 1ps

module c8_alu (
    input  c8_pkg::t_alu_req i_req,
    output c8_pkg::t_alu_rsp o_rsp
);

    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, i_req.a} + {1'b0, i_req.b};

    // byte operations with their flag
    always_comb begin
        o_rsp.y    = i_req.b;
        o_rsp.flag = 1'b0;
        case (i_req.op)
            ALU_MOV: o_rsp.y = i_req.b;
            ALU_OR:  o_rsp.y = i_req.a | i_req.b;
            ALU_AND: o_rsp.y = i_req.a & i_req.b;
            ALU_XOR: o_rsp.y = i_req.a ^ i_req.b;
            ALU_ADD: begin
                o_rsp.y    = sum[7:0];
                o_rsp.flag = sum[8];
            end
            ALU_SUB: begin
                o_rsp.y    = i_req.a - i_req.b;
                o_rsp.flag = (i_req.a >= i_req.b);
            end
            ALU_SUBN: begin
                o_rsp.y    = i_req.b - i_req.a;
                o_rsp.flag = (i_req.b >= i_req.a);
            end
            ALU_SHR: begin
                o_rsp.y    = {1'b0, i_req.a[7:1]};
                o_rsp.flag = i_req.a[0];
            end
            ALU_SHL: begin
                o_rsp.y    = {i_req.a[6:0], 1'b0};
                o_rsp.flag = i_req.a[7];
            end
            ALU_EQ: begin
                o_rsp.y    = i_req.a ^ i_req.b;
                o_rsp.flag = (i_req.a == i_req.b);
            end
            default: begin
                o_rsp.y    = i_req.b;
                o_rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

>>> test/chip8_checker.sv
`timescale 1ns / 1ps

module chip8_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    input  logic [2:0]  i_opcode,
    input  logic [11:0] i_load_address,
    input  logic [7:0]  i_load_data,
    input  logic [3:0]  i_key_number,
    input  logic        i_key_pressed,
    input  logic [4:0]  i_row_select,
    input  logic        o_strobe,
    input  logic [11:0] o_program_counter,
    input  logic [11:0] o_index_value,
    input  logic        o_display_changed,
    input  logic        o_waiting_key,
    input  logic        o_tone_on,
    input  logic        o_beep_pulse,
    input  logic [63:0] o_row_pixels,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_word_count
);

    import c8_pkg::*;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] idx;
        logic        drew;
        logic        waiting;
        logic        tone;
        logic        beep;
        logic [63:0] row;
    } t_machine_word;

    // shadow machine state
    logic [7:0]  mem [0:MEM_DEPTH-1];
    logic [63:0] frame [0:ROWS-1];
    logic [7:0]  vreg [0:NUM_REGS-1];
    logic [11:0] stk [0:STACK_D-1];
    logic [3:0]  sp;
    logic [11:0] pc, idx;
    logic [7:0]  dt, st;
    logic [15:0] keys, lfsr;
    logic        waiting;
    logic [3:0]  wait_reg;

    t_machine_word expected_words[$];

    task automatic clear_machine();
        for (int a = 0; a < MEM_DEPTH; a++) mem[a] = 8'h00;
        for (int a = 0; a < FONT_BYTES; a++) mem[FONT_BASE + a] = FONT[a];
        for (int r = 0; r < ROWS; r++) frame[r] = '0;
        for (int r = 0; r < NUM_REGS; r++) vreg[r] = 8'h00;
        for (int r = 0; r < STACK_D; r++) stk[r] = 12'h000;
        sp = 0; pc = START_RESET; idx = 0;
        dt = 0; st = 0; keys = 0; lfsr = LFSR_SEED; waiting = 0; wait_reg = 0;
    endtask

    // one instruction, returns 1 when the display was touched
    function automatic logic run_instruction();
        logic [15:0] inst;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, a, b, bits, rv;
        logic [11:0] nxt, skp;
        logic [8:0]  sum;
        logic        drew, hit, fb;
        logic [5:0]  cx;
        logic [4:0]  cy;
        inst = {mem[pc], mem[pc + 12'd1]};
        x = inst[11:8]; y = inst[7:4]; n = inst[3:0]; nn = inst[7:0];
        nxt = pc + 12'd2; skp = pc + 12'd4; drew = 0;
        a = vreg[x]; b = vreg[y];
        case (inst[15:12])
            4'h0: begin
                if (inst == INST_CLS) begin
                    for (int r = 0; r < ROWS; r++) frame[r] = '0;
                    drew = 1;
                end else if (inst == INST_RET && sp != 0) begin
                    sp = sp - 1;
                    nxt = stk[sp];
                end
            end
            4'h1: nxt = inst[11:0];
            4'h2: begin
                stk[sp] = pc + 12'd2;
                sp = sp + 1;
                nxt = inst[11:0];
            end
            4'h3: if (a == nn) nxt = skp;
            4'h4: if (a != nn) nxt = skp;
            4'h5: if (n == 0 && a == b) nxt = skp;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = a + nn;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = b;
                    4'h1: vreg[x] = a | b;
                    4'h2: vreg[x] = a & b;
                    4'h3: vreg[x] = a ^ b;
                    4'h4: begin
                        sum = a + b; vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin
                        fb = a >= b; vreg[x] = a - b; vreg[15] = {7'd0, fb};
                    end
                    4'h6: begin
                        vreg[x] = a >> 1; vreg[15] = {7'd0, a[0]};
                    end
                    4'h7: begin
                        fb = b >= a; vreg[x] = b - a; vreg[15] = {7'd0, fb};
                    end
                    4'hE: begin
                        vreg[x] = a << 1; vreg[15] = {7'd0, a[7]};
                    end
                    default: ;
                endcase
            end
            4'h9: if (n == 0 && a != b) nxt = skp;
            4'hA: idx = inst[11:0];
            4'hB: nxt = inst[11:0] + {4'd0, vreg[0]};
            4'hC: begin
                lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                rv = lfsr[7:0];
                vreg[x] = rv & nn;
            end
            4'hD: begin
                hit = 0;
                for (int r = 0; r < n; r++) begin
                    bits = mem[idx + r[11:0]];
                    cy = b[4:0] + r[4:0];
                    for (int c = 0; c < 8; c++) begin
                        if (bits[7 - c]) begin
                            cx = a[5:0] + c[5:0];
                            if (frame[cy][63 - cx]) hit = 1;
                            frame[cy][63 - cx] = ~frame[cy][63 - cx];
                        end
                    end
                end
                vreg[15] = {7'd0, hit};
                drew = 1;
            end
            4'hE: begin
                if (nn == NN_SKP && keys[a[3:0]]) nxt = skp;
                else if (nn == NN_SKNP && !keys[a[3:0]]) nxt = skp;
            end
            default: begin
                case (nn)
                    NN_GETDT: vreg[x] = dt;
                    NN_WAITK: begin
                        waiting = 1; wait_reg = x; nxt = pc;
                    end
                    NN_SETDT: dt = a;
                    NN_SETST: st = a;
                    NN_ADDI:  idx = idx + {4'd0, a};
                    NN_FONT:  idx = FONT_BASE + 12'd5 * {4'd0, a};
                    NN_BCD: begin
                        mem[idx] = a / 100;
                        mem[idx + 12'd1] = (a / 10) % 10;
                        mem[idx + 12'd2] = a % 10;
                    end
                    NN_STORE: for (int r = 0; r <= x; r++) mem[idx + r[11:0]] = vreg[r];
                    NN_LOAD:  for (int r = 0; r <= x; r++) vreg[r] = mem[idx + r[11:0]];
                    default: ;
                endcase
            end
        endcase
        pc = nxt;
        return drew;
    endfunction

    function automatic t_machine_word apply_event(logic [2:0] op, logic [11:0] la,
                                                  logic [7:0] ld, logic [3:0] kn,
                                                  logic kp, logic [4:0] rs);
        t_machine_word w;
        w = '0;
        case (op)
            EV_EXEC: if (!waiting) w.drew = run_instruction();
            EV_TICK: begin
                if (dt != 0) dt = dt - 1;
                if (st != 0) begin
                    st = st - 1;
                    w.beep = (st == 1);
                end
            end
            EV_KEY: begin
                if (kp) begin
                    keys[kn] = 1'b1;
                    if (waiting) begin
                        vreg[wait_reg] = {4'd0, kn};
                        pc = pc + 12'd2;
                        waiting = 0;
                    end
                end else begin
                    keys[kn] = 1'b0;
                end
            end
            EV_LOAD: mem[la] = ld;
            EV_ROW:  w.row = frame[rs];
            default: ;
        endcase
        w.pc = pc; w.idx = idx; w.waiting = waiting; w.tone = (st != 0);
        return w;
    endfunction

    assign o_pending = expected_words.size();

    // predict on accepted words, compare on strobes
    always @(posedge i_clk) begin
        t_machine_word got, exp_w;
        if (!i_rst_n) begin
            clear_machine();
            expected_words.delete();
            o_fail_count <= 0;
            o_word_count <= 0;
        end else begin
            if (o_strobe) begin
                got = {o_program_counter, o_index_value, o_display_changed, o_waiting_key,
                       o_tone_on, o_beep_pulse, o_row_pixels};
                o_word_count <= o_word_count + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result word pc=%h", $realtime, got.pc);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch exp pc=%h i=%h d=%b w=%b t=%b b=%b row=%h",
                                $realtime, exp_w.pc, exp_w.idx, exp_w.drew, exp_w.waiting,
                                exp_w.tone, exp_w.beep, exp_w.row);
                            $display("    got pc=%h i=%h d=%b w=%b t=%b b=%b row=%h",
                                got.pc, got.idx, got.drew, got.waiting, got.tone,
                                got.beep, got.row);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                pc = i_cfg_data;
            end
            if (start && !busy)
                expected_words.push_back(apply_event(i_opcode, i_load_address, i_load_data,
                                                     i_key_number, i_key_pressed,
                                                     i_row_select));
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import c8_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_cfg_we = 0;
    logic [11:0] i_cfg_data = 0;
    logic [2:0]  i_opcode = 0;
    logic [11:0] i_load_address = 0;
    logic [7:0]  i_load_data = 0;
    logic [3:0]  i_key_number = 0;
    logic        i_key_pressed = 0;
    logic [4:0]  i_row_select = 0;
    logic        o_strobe, o_display_changed, o_waiting_key, o_tone_on, o_beep_pulse;
    logic [11:0] o_program_counter, o_index_value;
    logic [63:0] o_row_pixels;
    int          fail_count, pending, word_count;
    int          sent_count;
    logic        quiet;
    logic [11:0] prog_base;

    always #1 i_clk = ~i_clk;

    chip8_interpreter_core DUT (.*);

    chip8_checker checker_inst (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_word_count(word_count)
    );

    // one event word, held until accepted; start stays up until the next gap or drain
    task automatic send_event(logic [2:0] op, logic [11:0] la, logic [7:0] ld,
                              logic [3:0] kn, logic kp, logic [4:0] rs);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_opcode <= op; i_load_address <= la; i_load_data <= ld;
        i_key_number <= kn; i_key_pressed <= kp; i_row_select <= rs;
        do @(posedge i_clk); while (busy);
        sent_count++;
    endtask

    task automatic load_byte(logic [11:0] a, logic [7:0] d);
        send_event(EV_LOAD, a, d, 0, 0, 0);
    endtask

    task automatic load_inst(logic [11:0] a, logic [15:0] inst);
        load_byte(a, inst[15:8]);
        load_byte(a + 12'd1, inst[7:0]);
    endtask

    task automatic exec_one();
        send_event(EV_EXEC, 12'($urandom), 8'($urandom), 4'($urandom), 1'($urandom),
                   5'($urandom));
    endtask

    task automatic drain();
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_start(logic [11:0] a);
        drain();
        i_cfg_we <= 1; i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // one random instruction, biased toward A, 6, 8XY, D, C and FX33/FX55/FX65 ops
    function automatic logic [15:0] random_inst();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            0: w = {4'hA, 1'b0, w[10:0]};
            1: w = {4'h6, w[11:0]};
            2: w = {4'h8, w[11:4], 4'($urandom_range(0, 7))};
            3: w = {4'hD, w[11:0]};
            4: w = {4'hF, w[11:8], 8'h33};
            5: w = {4'hF, w[11:8], 8'h65};
            6: w = {4'hF, w[11:8], 8'h55};
            7: w = {4'hC, w[11:0]};
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [15:0] dir_prog [0:21];
        dir_prog = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8F15, 16'h6201, 16'h8216,
                     16'h8127, 16'h811E, 16'hA050, 16'hD01F, 16'hD01F, 16'hF033,
                     16'hFF55, 16'hFF65, 16'hF329, 16'hF01E, 16'h2300, 16'h00EE,
                     16'h00EE, 16'hF118, 16'hF015, 16'hF50A};
        quiet = 0; sent_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: an instruction mix at 0x200
        for (int k = 0; k < 22; k++) load_inst(12'h200 + 12'(2 * k), dir_prog[k]);
        load_inst(12'h300, 16'h00EE);
        for (int k = 0; k < 22; k++) exec_one();
        exec_one();
        send_event(EV_KEY, 0, 0, 4'hF, 1, 0);
        send_event(EV_KEY, 0, 0, 4'hF, 0, 0);
        for (int k = 0; k < 4; k++) send_event(EV_TICK, 0, 0, 0, 0, 0);
        send_event(EV_ROW, 0, 0, 0, 0, 5'd31);
        send_event(EV_ROW, 0, 0, 0, 0, 5'd0);
        send_event(3'd7, 12'hFFF, 8'hFF, 4'hF, 1, 5'd31);
        load_byte(12'hFFF, 8'hFF);
        // random phases over several start addresses
        for (int ph = 0; ph < 6; ph++) begin
            prog_base = (ph == 0) ? 12'h000 : (ph == 1) ? 12'hFF0
                      : 12'($urandom_range(12'h200, 12'hF00));
            set_start(prog_base);
            if (ph == 5) quiet = 1;
            for (int k = 0; k < 8; k++)
                load_inst(prog_base + 12'(2 * k), random_inst());
            for (int k = 0; k < 50; k++) begin
                case ($urandom_range(0, 9))
                    0: send_event(EV_TICK, 0, 0, 0, 0, 0);
                    1: send_event(EV_KEY, 0, 0, 4'($urandom), 1'($urandom), 0);
                    2: load_byte(12'($urandom), 8'($urandom));
                    3: send_event(EV_ROW, 0, 0, 0, 0, 5'($urandom));
                    4: send_event(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom),
                                  4'($urandom), 1'($urandom), 5'($urandom));
                    default: exec_one();
                endcase
            end
        end
        set_start(12'hFFF);
        set_start(12'h200);
        drain();
        $display("sent %0d event words, checked %0d results across instruction, timer,",
                 sent_count, word_count);
        $display("key, load and row events under several start addresses");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #500000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
